// File: sv/gn3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types, constants and helper functions of the gradient noise block.
// ----------------------------------------------------------------------------
package gn3_pkg;

    localparam int COORD_W    = 24;   // Q8.16 coordinate word
    localparam int FRAC_W     = 16;   // fraction bits of a coordinate
    localparam int OUT_FRAC_W = 14;   // fraction bits of the result
    localparam int SCALE_SH   = FRAC_W - OUT_FRAC_W;
    localparam int PERM_SIZE  = 256;
    localparam int PERM_AW    = 8;
    localparam int FADE_W     = FRAC_W + 1;   // fade value in [0, one]
    localparam int VAL_W      = FRAC_W + 3;   // gradient and lerp values
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = DIFF_W + FADE_W + 1;
    localparam int ACC_W      = 24;
    localparam int OCT_W      = 5;
    localparam int MAX_OCTAVES = 16;
    localparam int RES_W      = 16;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_NOISE  = 2'd1,
        KIND_OCTAVE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FADE,
        ST_HASH,
        ST_GRAD,
        ST_LERP,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               en;
        logic [PERM_AW-1:0] addr;
        logic [7:0]         data;
    } mem_wr_t;

    typedef struct packed {
        logic [2:0] a_idx;
        logic [2:0] b_idx;
        logic [1:0] axis;
    } lerp_op_t;

    // Lerp schedule: the four x lerps, the two y lerps, then the z lerp.
    // The result always replaces operand a.
    function automatic lerp_op_t lerp_op(input logic [2:0] op);
        lerp_op_t r;
        unique case (op)
            3'd0:    r = '{a_idx: 3'd0, b_idx: 3'd4, axis: 2'd0};
            3'd1:    r = '{a_idx: 3'd2, b_idx: 3'd6, axis: 2'd0};
            3'd2:    r = '{a_idx: 3'd1, b_idx: 3'd5, axis: 2'd0};
            3'd3:    r = '{a_idx: 3'd3, b_idx: 3'd7, axis: 2'd0};
            3'd4:    r = '{a_idx: 3'd0, b_idx: 3'd2, axis: 2'd1};
            3'd5:    r = '{a_idx: 3'd1, b_idx: 3'd3, axis: 2'd1};
            default: r = '{a_idx: 3'd0, b_idx: 3'd1, axis: 2'd2};
        endcase
        return r;
    endfunction

    // Gradient dot product selected by the low four hash bits.
    function automatic logic signed [VAL_W-1:0] grad_f(
        input logic [3:0]              h,
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y,
        input logic signed [VAL_W-1:0] z
    );
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        a = (h < 4'd8) ? x : y;
        b = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        if (h[0])
        begin
            a = -a;
        end
        if (h[1])
        begin
            b = -b;
        end
        return a + b;
    endfunction

endpackage

// File: sv/gn3_perm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_perm_mem
// Permutation table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gn3_perm_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gn3_pkg::mem_wr_t              wr,
    input  logic [gn3_pkg::PERM_AW-1:0]   rd_addr,
    output logic [7:0]                    rd_data
);
    import gn3_pkg::*;

    logic [7:0]         mem [PERM_SIZE];
    logic [PERM_SIZE-1:0] valid_reg;
    logic [7:0]         mem_q_reg;
    logic [PERM_AW-1:0] addr_q_reg;
    logic               vld_q_reg;
    logic               fwd_q_reg;
    logic [7:0]         fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg    <= mem[rd_addr];
        addr_q_reg   <= rd_addr;
        fwd_data_reg <= wr.data;
    end

    // An entry never written reads as its own index (identity after reset).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
            fwd_q_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            vld_q_reg <= valid_reg[rd_addr];
            fwd_q_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = fwd_q_reg ? fwd_data_reg : (vld_q_reg ? mem_q_reg : addr_q_reg);

endmodule

// File: sv/gn3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3_core
// Sequencer for one noise evaluation or octave sum: fade, table hashing, gradients, lerps, accumulation.
// ----------------------------------------------------------------------------
module gn3_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                octave,
    input  logic [gn3_pkg::COORD_W-1:0]         cx,
    input  logic [gn3_pkg::COORD_W-1:0]         cy,
    input  logic [gn3_pkg::COORD_W-1:0]         cz,
    input  logic [gn3_pkg::OCT_W-1:0]           layers,
    output logic                                ready,
    output logic [gn3_pkg::PERM_AW-1:0]         rd_addr,
    input  logic [7:0]                          rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [gn3_pkg::RES_W-1:0]    res_value,
    output logic                                res_sat
);
    import gn3_pkg::*;

    state_t state_reg, state_next;

    logic [3:0]          step_reg;
    logic [1:0]          axis_reg;
    logic [OCT_W-1:0]    layer_reg;
    logic [OCT_W-1:0]    nlay_reg;
    logic                octave_reg;

    logic [COORD_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [FRAC_W-1:0]   pw_reg, t3_reg, t4_reg;
    logic [FADE_W-1:0]   fade_reg [3];
    logic [PERM_AW-1:0]  a_reg, b_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic [3:0]          g_reg [8];
    logic signed [VAL_W-1:0]  l_reg [8];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [FRAC_W-1:0]   fx, fy, fz, t_sel, pw_src;
    logic [PERM_AW-1:0]  cell_x, cell_y, cell_z;
    logic [2*FRAC_W-1:0] pw_prod;
    logic signed [ACC_W-1:0]  fade_raw;
    logic [FADE_W-1:0]   fade_val;
    lerp_op_t            op;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  scaled;

    assign fx     = cx_reg[FRAC_W-1:0];
    assign fy     = cy_reg[FRAC_W-1:0];
    assign fz     = cz_reg[FRAC_W-1:0];
    assign cell_x = cx_reg[FRAC_W+PERM_AW-1:FRAC_W];
    assign cell_y = cy_reg[FRAC_W+PERM_AW-1:FRAC_W];
    assign cell_z = cz_reg[FRAC_W+PERM_AW-1:FRAC_W];

    // Fade: t2..t5 by repeated multiply, then the polynomial and clamp.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    t_sel = fx;
            2'd1:    t_sel = fy;
            default: t_sel = fz;
        endcase
        pw_src   = (step_reg == 4'd0) ? t_sel : pw_reg;
        pw_prod  = pw_src * t_sel;
        fade_raw = ACC_W'(6) * $signed({8'd0, pw_reg})
                 - ACC_W'(15) * $signed({8'd0, t4_reg})
                 + ACC_W'(10) * $signed({8'd0, t3_reg});
        if (fade_raw < 0)
        begin
            fade_val = '0;
        end
        else if (fade_raw > $signed(ACC_W'(1 << FRAC_W)))
        begin
            fade_val = FADE_W'(1 << FRAC_W);
        end
        else
        begin
            fade_val = fade_raw[FADE_W-1:0];
        end
    end

    // Table read address for each hash step.
    always_comb
    begin
        unique case (step_reg)
            4'd0:    rd_addr = cell_x;
            4'd1:    rd_addr = cell_x + 8'd1;
            4'd2:    rd_addr = a_reg;
            4'd3:    rd_addr = a_reg + 8'd1;
            4'd4:    rd_addr = b_reg;
            4'd5:    rd_addr = b_reg + 8'd1;
            4'd6:    rd_addr = aa_reg;
            4'd7:    rd_addr = aa_reg + 8'd1;
            4'd8:    rd_addr = ab_reg;
            4'd9:    rd_addr = ab_reg + 8'd1;
            4'd10:   rd_addr = ba_reg;
            4'd11:   rd_addr = ba_reg + 8'd1;
            4'd12:   rd_addr = bb_reg;
            4'd13:   rd_addr = bb_reg + 8'd1;
            default: rd_addr = cell_x;
        endcase
    end

    assign op   = lerp_op(step_reg[3:1]);
    assign diff = {l_reg[op.b_idx][VAL_W-1], l_reg[op.b_idx]}
                - {l_reg[op.a_idx][VAL_W-1], l_reg[op.a_idx]};

    assign scaled    = acc_reg >>> SCALE_SH;
    assign res_sat   = (scaled > $signed(ACC_W'(32767))) || (scaled < -$signed(ACC_W'(32768)));
    assign res_value = (scaled > $signed(ACC_W'(32767))) ? RES_W'(32767) :
                       (scaled < -$signed(ACC_W'(32768))) ? -RES_W'(32768) :
                       scaled[RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ready      = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    state_next = (octave && layers == '0) ? ST_DONE : ST_FADE;
                end
            end
            ST_FADE:
            begin
                if (step_reg == 4'd4 && axis_reg == 2'd2)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (step_reg == 4'd14)
                begin
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD:
            begin
                state_next = ST_LERP;
            end
            ST_LERP:
            begin
                if (step_reg == 4'd13)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (octave_reg && (layer_reg + 5'd1) < nlay_reg)
                begin
                    state_next = ST_FADE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Step, axis and layer counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            axis_reg   <= '0;
            layer_reg  <= '0;
            nlay_reg   <= '0;
            octave_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg   <= '0;
                    axis_reg   <= '0;
                    layer_reg  <= '0;
                    nlay_reg   <= layers;
                    octave_reg <= octave;
                end
                ST_FADE:
                begin
                    if (step_reg == 4'd4)
                    begin
                        step_reg <= '0;
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_HASH:
                begin
                    step_reg <= (step_reg == 4'd14) ? 4'd0 : step_reg + 4'd1;
                end
                ST_GRAD:
                begin
                    step_reg <= '0;
                end
                ST_LERP:
                begin
                    step_reg <= (step_reg == 4'd13) ? 4'd0 : step_reg + 4'd1;
                end
                ST_ACC:
                begin
                    step_reg  <= '0;
                    axis_reg  <= '0;
                    layer_reg <= layer_reg + 5'd1;
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cx_reg  <= cx;
                    cy_reg  <= cy;
                    cz_reg  <= octave ? '0 : cz;
                    acc_reg <= '0;
                end
            end
            ST_FADE:
            begin
                if (step_reg == 4'd4)
                begin
                    fade_reg[axis_reg] <= fade_val;
                end
                else
                begin
                    pw_reg <= pw_prod[2*FRAC_W-1:FRAC_W];
                    if (step_reg == 4'd1)
                    begin
                        t3_reg <= pw_prod[2*FRAC_W-1:FRAC_W];
                    end
                    if (step_reg == 4'd2)
                    begin
                        t4_reg <= pw_prod[2*FRAC_W-1:FRAC_W];
                    end
                end
            end
            ST_HASH:
            begin
                unique case (step_reg)
                    4'd1:    a_reg  <= rd_data + cell_y;
                    4'd2:    b_reg  <= rd_data + cell_y;
                    4'd3:    aa_reg <= rd_data + cell_z;
                    4'd4:    ab_reg <= rd_data + cell_z;
                    4'd5:    ba_reg <= rd_data + cell_z;
                    4'd6:    bb_reg <= rd_data + cell_z;
                    4'd0:    ;
                    default: g_reg[3'(step_reg + 4'd1)] <= rd_data[3:0];
                endcase
            end
            ST_GRAD:
            begin
                // Corner index bits: bit 2 selects x-1, bit 1 y-1, bit 0 z-1.
                for (int c = 0; c < 8; c++)
                begin
                    l_reg[c] <= grad_f(g_reg[c],
                        $signed({3'b0, fx}) - (c[2] ? VAL_W'(1 << FRAC_W) : VAL_W'(0)),
                        $signed({3'b0, fy}) - (c[1] ? VAL_W'(1 << FRAC_W) : VAL_W'(0)),
                        $signed({3'b0, fz}) - (c[0] ? VAL_W'(1 << FRAC_W) : VAL_W'(0)));
                end
            end
            ST_LERP:
            begin
                if (!step_reg[0])
                begin
                    prod_reg <= $signed({1'b0, fade_reg[op.axis]}) * diff;
                end
                else
                begin
                    l_reg[op.a_idx] <= l_reg[op.a_idx] + prod_reg[FRAC_W+VAL_W-1:FRAC_W];
                end
            end
            ST_ACC:
            begin
                if (octave_reg)
                begin
                    acc_reg <= acc_reg
                             + ($signed({{(ACC_W-VAL_W){l_reg[0][VAL_W-1]}}, l_reg[0]})
                                >>> layer_reg);
                    cx_reg  <= {cx_reg[COORD_W-2:0], 1'b0};
                    cy_reg  <= {cy_reg[COORD_W-2:0], 1'b0};
                end
                else
                begin
                    acc_reg <= {{(ACC_W-VAL_W){l_reg[0][VAL_W-1]}}, l_reg[0]};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/gradient_noise_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved gradient noise (3D samples and 2D octave sums) from a loadable
// 256-entry permutation table.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit first)
//  s_*       in   tuser: kind[1:0]; tdata: coord_x, coord_y, coord_z,
//                 entry_index, entry_value (88 bits)
//  m_*       out  tdata: noise_value[15:0]; tuser: saturated
//  cfg_*     in   cfg_wdata: octave_count[4:0], written when cfg_wen is high
//
// A load word is written into the table when accepted. A noise word runs
// fade, hash, gradient, lerp and accumulate, then hands off the result; an
// octave word runs those phases once per layer. The single table read port
// paces the hash phase, and the shared multipliers pace the fade and lerp
// phases. Reset clears the control state and the table reads as identity
// without a clearing pass. A finished result waits in the output register,
// so a stalled m_tready only blocks input once the next result is also done.
// ----------------------------------------------------------------------------
module gradient_noise_3d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // coord_x, coord_y, coord_z, entry_index, entry_value
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // noise_value
    output logic        m_tuser,   // saturated
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata  // octave_count
);
    import gn3_pkg::*;

    logic [OCT_W-1:0]   octave_count_reg;
    logic [OCT_W-1:0]   layers;
    logic               s_fire;
    logic               core_ready;
    logic               core_start;
    mem_wr_t            wr;
    logic [PERM_AW-1:0] rd_addr;
    logic [7:0]         rd_data;
    logic               res_valid;
    logic               res_ready;
    logic signed [RES_W-1:0] res_value;
    logic               res_sat;
    logic               m_tvalid_reg;
    logic [RES_W-1:0]   m_tdata_reg;
    logic               m_tuser_reg;
    kind_t              kind;

    assign kind     = kind_t'(s_tuser);
    assign s_tready = core_ready;
    assign s_fire   = s_tvalid && s_tready;

    // Loads go straight into the table; both evaluating kinds start the core.
    assign core_start = s_fire && (kind == KIND_NOISE || kind == KIND_OCTAVE);
    assign wr.en      = s_fire && (kind == KIND_LOAD);
    assign wr.addr    = s_tdata[79:72];
    assign wr.data    = s_tdata[87:80];

    // Layer counts above the maximum are clipped.
    assign layers = (octave_count_reg > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                             : octave_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCT_W'(4);
        end
        else if (cfg_wen)
        begin
            octave_count_reg <= cfg_wdata;
        end
    end

    gn3_perm_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gn3_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .octave    (kind == KIND_OCTAVE),
        .cx        (s_tdata[23:0]),
        .cy        (s_tdata[47:24]),
        .cz        (s_tdata[71:48]),
        .layers    (layers),
        .ready     (core_ready),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value),
        .res_sat   (res_sat)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= res_value;
            m_tuser_reg <= res_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
